[hw/rtl/hnl_pkg.sv]
// Package for the terrain cell lighting block: payload and command types,
// sizes, register indexes and state encodings. It depends on nothing else.
package hnl_pkg;

   localparam int GRID_SIZE   = 128;
   localparam int GRID_BITS   = 7;
   localparam int ADDR_BITS   = 14;
   localparam int MEM_DEPTH   = GRID_SIZE * GRID_SIZE;
   localparam int CELL_WIDTH  = 32;
   localparam int EDGE_HIGH   = 98;
   localparam int LEVEL_HALF  = 30;
   localparam int LEVEL_MAX   = 60;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int K_BITS      = 18;
   localparam int D_BITS      = 28;
   localparam int KK_BITS     = 35;
   localparam int LL_BITS     = 18;
   localparam int S_BITS      = 18;
   localparam int LIGHT_RESET_X = -150;
   localparam int LIGHT_RESET_Y = -150;
   localparam int LIGHT_RESET_Z = 180;

   typedef enum logic [1:0] {
      CSR_LIGHT_X = 2'd0,
      CSR_LIGHT_Y = 2'd1,
      CSR_LIGHT_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [6:0] cell_x;
      logic [6:0] cell_y;
      logic [7:0] height_top_left;
      logic [7:0] height_top_right;
      logic [7:0] height_bottom_right;
      logic [7:0] height_bottom_left;
   } req_type;

   typedef struct packed {
      logic [5:0] light_level;
      logic       updated;
   } rsp_type;

   typedef struct packed {
      logic signed [8:0] x;
      logic signed [8:0] y;
      logic signed [8:0] z;
   } light_type;

   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cz;
   } normal_type;

   // One classified item as it waits between the front and the back.
   typedef struct packed {
      logic                    interior;
      logic [GRID_BITS-1:0]    x;
      logic [GRID_BITS-1:0]    y;
      logic signed [8:0]       ua;
      logic signed [8:0]       ub;
      logic signed [8:0]       la;
      logic signed [8:0]       lb;
      logic [S_BITS-1:0]       s_up;
      logic [S_BITS-1:0]       s_lo;
   } cmd_type;

   typedef struct packed {
      logic              start;
      logic signed [8:0] c;
      logic [S_BITS-1:0] s;
   } unit_req_type;

   typedef struct packed {
      logic               done;
      logic signed [15:0] comp;
   } unit_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] x;
      logic [31:0] y;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   typedef enum logic [1:0] {
      UNIT_IDLE,
      UNIT_DIV,
      UNIT_SQRT
   } unit_state_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_NORM_START,
      BK_NORM_WAIT,
      BK_STORE,
      BK_READ,
      BK_ACC,
      BK_DOT,
      BK_PROD,
      BK_PWAIT,
      BK_SQ,
      BK_SQWAIT,
      BK_SRCH,
      BK_SWAIT,
      BK_OUT
   } back_state_type;

   function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [GRID_BITS-1:0] y,
                                                      input logic [GRID_BITS-1:0] x);
      cell_addr = ADDR_BITS'(ADDR_BITS'(y) * ADDR_BITS'(GRID_SIZE) + ADDR_BITS'(x));
   endfunction

endpackage

[hw/rtl/hnl_front.sv]
// Front of the lighting block: takes items, flags edge cells and forms the
// height steps and squared lengths of both triangles. Uses hnl_pkg.
module hnl_front (
   input  logic             req_valid,
   input  hnl_pkg::req_type req_data,
   output logic             req_stall,
   input  logic             clearing,
   input  logic             queue_full,
   output logic             push,
   output hnl_pkg::cmd_type cmd
);
   import hnl_pkg::*;

   logic signed [8:0]  tl, tr, br, bl;
   logic signed [17:0] sq_ua, sq_ub, sq_la, sq_lb;

   always_comb begin
      tl = signed'({1'b0, req_data.height_top_left});
      tr = signed'({1'b0, req_data.height_top_right});
      br = signed'({1'b0, req_data.height_bottom_right});
      bl = signed'({1'b0, req_data.height_bottom_left});
      cmd.x  = req_data.cell_x;
      cmd.y  = req_data.cell_y;
      cmd.ua = tl - tr;
      cmd.ub = tl - bl;
      cmd.la = bl - br;
      cmd.lb = tr - br;
      sq_ua = cmd.ua * cmd.ua;
      sq_ub = cmd.ub * cmd.ub;
      sq_la = cmd.la * cmd.la;
      sq_lb = cmd.lb * cmd.lb;
      cmd.s_up = S_BITS'(sq_ua) + S_BITS'(sq_ub) + S_BITS'(CELL_WIDTH * CELL_WIDTH);
      cmd.s_lo = S_BITS'(sq_la) + S_BITS'(sq_lb) + S_BITS'(CELL_WIDTH * CELL_WIDTH);
      cmd.interior = (32'(req_data.cell_x) >= 32'd1) && (32'(req_data.cell_x) <= EDGE_HIGH) &&
                     (32'(req_data.cell_y) >= 32'd1) && (32'(req_data.cell_y) <= EDGE_HIGH) &&
                     (32'(req_data.cell_x) < GRID_SIZE) && (32'(req_data.cell_y) < GRID_SIZE);
      req_stall = clearing || queue_full;
      push      = req_valid && !req_stall;
   end

endmodule

[hw/rtl/hnl_queue.sv]
// Short command queue between the front and the back of the lighting block.
// Uses hnl_pkg for the entry type and depth.
module hnl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hnl_pkg::cmd_type push_data,
   input  logic             pop,
   output hnl_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);
   import hnl_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;

   always_comb begin
      full      = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full && !pop))
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset)
                    count_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue count beyond its depth");

endmodule

[hw/rtl/hnl_unit.sv]
// Shared normalising unit: sign(c) * isqrt(floor(c*c*2^28 / s)) by a
// restoring divide, one bit a cycle, then a digit-by-digit square root.
// Uses hnl_pkg.
module hnl_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  hnl_pkg::unit_req_type req,
   output hnl_pkg::unit_rsp_type rsp
);
   import hnl_pkg::*;

   unit_state_type     state_ff, state_in;
   logic [S_BITS-1:0]  rem_ff, rem_in;
   logic [S_BITS-1:0]  div_ff, div_in;
   logic [28:0]        q_ff, q_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               lsb_ff, lsb_in;
   logic               neg_ff, neg_in;
   logic [29:0]        v_ff, v_in;
   logic [29:0]        r_ff, r_in;
   logic               done_ff, done_in;
   logic signed [15:0] res_ff, res_in;
   logic [8:0]         mag;
   logic [17:0]        msq;
   logic [S_BITS:0]    trial;
   logic [29:0]        bitv;
   logic [29:0]        r_next;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      lsb_in   = lsb_ff;
      neg_in   = neg_ff;
      v_in     = v_ff;
      r_in     = r_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      mag      = req.c[8] ? 9'(-req.c) : 9'(req.c);
      msq      = 18'(mag) * 18'(mag);
      trial    = {rem_ff, ((cnt_ff == 5'd28) ? lsb_ff : 1'b0)};
      bitv     = 30'd1 << {cnt_ff[3:0], 1'b0};
      r_next   = 30'(r_ff + bitv);
      case (state_ff)
         UNIT_IDLE: begin
            if (req.start) begin
               rem_in   = S_BITS'(msq >> 1);
               lsb_in   = msq[0];
               div_in   = req.s;
               neg_in   = req.c[8];
               q_in     = '0;
               cnt_in   = 5'd28;
               state_in = UNIT_DIV;
            end
         end
         UNIT_DIV: begin
            if (trial >= {1'b0, div_ff}) begin
               rem_in = S_BITS'(trial - {1'b0, div_ff});
               q_in   = {q_ff[27:0], 1'b1};
            end else begin
               rem_in = S_BITS'(trial);
               q_in   = {q_ff[27:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               v_in     = 30'(q_in);
               r_in     = '0;
               cnt_in   = 5'd14;
               state_in = UNIT_SQRT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         UNIT_SQRT: begin
            if (v_ff >= r_next) begin
               v_in = v_ff - r_next;
               r_in = (r_ff >> 1) + bitv;
            end else begin
               r_in = r_ff >> 1;
            end
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               res_in   = neg_ff ? -16'(r_in) : 16'(r_in);
               state_in = UNIT_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: state_in = UNIT_IDLE;
      endcase
      rsp.done = done_ff;
      rsp.comp = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= UNIT_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      lsb_ff <= lsb_in;
      neg_ff <= neg_in;
      v_ff   <= v_in;
      r_ff   <= r_in;
      res_ff <= res_in;
   end

endmodule

[hw/rtl/hnl_mul.sv]
// Shift-and-add multiplier of the back end: one multiplier bit a cycle,
// finishing as soon as the remaining multiplier bits are zero. Uses hnl_pkg.
module hnl_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  hnl_pkg::mul_req_type req,
   output hnl_pkg::mul_rsp_type rsp
);
   import hnl_pkg::*;

   logic        busy_ff, busy_in;
   logic [63:0] x_ff, x_in;
   logic [31:0] y_ff, y_in;
   logic [63:0] acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         busy_in = 1'b1;
         x_in    = req.x;
         y_in    = req.y;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (y_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            acc_in = y_ff[0] ? acc_ff + x_ff : acc_ff;
            x_in   = x_ff << 1;
            y_in   = y_ff >> 1;
         end
      end
      rsp.done    = busy_ff && (y_ff == '0);
      rsp.product = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

endmodule

[hw/rtl/hnl_back.sv]
// Back end of the lighting block: normal tables, neighbour sum, dot product
// and the brightness search. Uses hnl_pkg, hnl_unit and hnl_mul.
module hnl_back (
   input  logic               clock,
   input  logic               reset,
   input  hnl_pkg::light_type light,
   input  hnl_pkg::cmd_type   head,
   input  logic               empty,
   output logic               pop,
   output logic               clearing,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output hnl_pkg::rsp_type   rsp_data
);
   import hnl_pkg::*;

   back_state_type          state_ff, state_in;
   logic [ADDR_BITS-1:0]    clr_addr_ff, clr_addr_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [2:0]              comp_ff, comp_in;
   normal_type              up_ff, up_in;
   normal_type              lo_ff, lo_in;
   logic [2:0]              rd_ff, rd_in;
   logic signed [K_BITS-1:0] k_ff [3];
   logic signed [K_BITS-1:0] k_in [3];
   logic [1:0]              j_ff, j_in;
   logic signed [D_BITS-1:0] d_ff, d_in;
   logic [KK_BITS-1:0]      kk_ff, kk_in;
   logic [LL_BITS-1:0]      ll_ff, ll_in;
   logic [63:0]             p_ff, p_in;
   logic [63:0]             b2_ff, b2_in;
   logic [5:0]              t_ff, t_in;
   logic [2:0]              sbit_ff, sbit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [47:0]             upper_mem [MEM_DEPTH];
   logic [47:0]             lower_mem [MEM_DEPTH];
   logic                    wr_en;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [47:0]             wr_up, wr_lo;
   logic [ADDR_BITS-1:0]    rd_addr;
   logic [47:0]             up_rd_ff, lo_rd_ff;

   unit_req_type            unit_req;
   unit_rsp_type            unit_rsp;
   mul_req_type             mul_req;
   mul_rsp_type             mul_rsp;

   normal_type              nb;
   logic signed [K_BITS-1:0] kj;
   logic signed [8:0]       lj;
   logic signed [D_BITS-1:0] lk;
   logic signed [35:0]      ksq;
   logic signed [17:0]      lsq;
   logic [D_BITS-1:0]       dabs;
   logic [31:0]             bmag;
   logic [5:0]              cand;
   logic signed [6:0]       a_s;
   logic signed [13:0]      a_sq;
   logic                    b_neg;
   logic                    fits;

   hnl_unit u_unit (
      .clock (clock),
      .reset (reset),
      .req   (unit_req),
      .rsp   (unit_rsp)
   );

   hnl_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cmd_in       = cmd_ff;
      comp_in      = comp_ff;
      up_in        = up_ff;
      lo_in        = lo_ff;
      rd_in        = rd_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      d_in         = d_ff;
      kk_in        = kk_ff;
      ll_in        = ll_ff;
      p_in         = p_ff;
      b2_in        = b2_ff;
      t_in         = t_ff;
      sbit_in      = sbit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cell_addr(cmd_ff.y, cmd_ff.x);
      wr_up        = up_ff;
      wr_lo        = lo_ff;
      rd_addr      = '0;
      unit_req     = '0;
      mul_req      = '0;

      // Signed selections used by several states.
      case (j_ff)
         2'd0:    begin kj = k_ff[0]; lj = light.x; end
         2'd1:    begin kj = k_ff[1]; lj = light.y; end
         default: begin kj = k_ff[2]; lj = light.z; end
      endcase
      lk    = D_BITS'(lj) * D_BITS'(kj);
      ksq   = kj * kj;
      lsq   = lj * lj;
      b_neg = d_ff[D_BITS-1];
      dabs  = b_neg ? D_BITS'(-d_ff) : D_BITS'(d_ff);
      bmag  = 32'(32'(dabs) * 32'(LEVEL_HALF));
      cand  = t_ff | (6'd1 << sbit_ff);
      a_s   = 7'(signed'({1'b0, cand})) - 7'(LEVEL_HALF);
      a_sq  = a_s * a_s;
      fits  = (a_s > 0) ? (mul_rsp.product <= b2_ff) : (mul_rsp.product >= b2_ff);
      nb    = (rd_ff <= 3'd1) ? normal_type'(up_rd_ff) : normal_type'(lo_rd_ff);

      case (rd_ff)
         3'd0:    rd_addr = cell_addr(cmd_ff.y - 1'b1, cmd_ff.x);
         3'd1:    rd_addr = cell_addr(cmd_ff.y, cmd_ff.x - 1'b1);
         3'd2:    rd_addr = cell_addr(cmd_ff.y - 1'b1, cmd_ff.x - 1'b1);
         3'd3:    rd_addr = cell_addr(cmd_ff.y, cmd_ff.x - 1'b1);
         default: rd_addr = cell_addr(cmd_ff.y - 1'b1, cmd_ff.x);
      endcase

      case (comp_ff)
         3'd0:    begin unit_req.c = cmd_ff.ua; unit_req.s = cmd_ff.s_up; end
         3'd1:    begin unit_req.c = cmd_ff.ub; unit_req.s = cmd_ff.s_up; end
         3'd2:    begin unit_req.c = 9'(CELL_WIDTH); unit_req.s = cmd_ff.s_up; end
         3'd3:    begin unit_req.c = cmd_ff.la; unit_req.s = cmd_ff.s_lo; end
         3'd4:    begin unit_req.c = cmd_ff.lb; unit_req.s = cmd_ff.s_lo; end
         default: begin unit_req.c = 9'(CELL_WIDTH); unit_req.s = cmd_ff.s_lo; end
      endcase

      case (state_ff)
         BK_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_up       = '0;
            wr_lo       = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!empty) begin
               pop     = 1'b1;
               cmd_in  = head;
               comp_in = '0;
               if (head.interior) begin
                  state_in = BK_NORM_START;
               end else begin
                  t_in     = '0;
                  state_in = BK_OUT;
               end
            end
         end
         BK_NORM_START: begin
            unit_req.start = 1'b1;
            state_in       = BK_NORM_WAIT;
         end
         BK_NORM_WAIT: begin
            if (unit_rsp.done) begin
               case (comp_ff)
                  3'd0:    up_in.cx = unit_rsp.comp;
                  3'd1:    up_in.cy = unit_rsp.comp;
                  3'd2:    up_in.cz = unit_rsp.comp;
                  3'd3:    lo_in.cx = unit_rsp.comp;
                  3'd4:    lo_in.cy = unit_rsp.comp;
                  default: lo_in.cz = unit_rsp.comp;
               endcase
               if (comp_ff == 3'd5) begin
                  state_in = BK_STORE;
               end else begin
                  comp_in  = comp_ff + 1'b1;
                  state_in = BK_NORM_START;
               end
            end
         end
         BK_STORE: begin
            wr_en    = 1'b1;
            k_in[0]  = K_BITS'(up_ff.cx);
            k_in[1]  = K_BITS'(up_ff.cy);
            k_in[2]  = K_BITS'(up_ff.cz);
            rd_in    = '0;
            state_in = BK_READ;
         end
         BK_READ: begin
            state_in = BK_ACC;
         end
         BK_ACC: begin
            k_in[0] = k_ff[0] + K_BITS'(nb.cx);
            k_in[1] = k_ff[1] + K_BITS'(nb.cy);
            k_in[2] = k_ff[2] + K_BITS'(nb.cz);
            if (rd_ff == 3'd4) begin
               j_in     = '0;
               d_in     = '0;
               kk_in    = '0;
               ll_in    = '0;
               state_in = BK_DOT;
            end else begin
               rd_in    = rd_ff + 1'b1;
               state_in = BK_READ;
            end
         end
         BK_DOT: begin
            d_in  = d_ff + lk;
            kk_in = kk_ff + ksq[KK_BITS-1:0];
            ll_in = ll_ff + LL_BITS'(lsq);
            if (j_ff == 2'd2) begin
               state_in = BK_PROD;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         BK_PROD: begin
            if (ll_ff == '0) begin
               t_in     = 6'(LEVEL_HALF);
               state_in = BK_OUT;
            end else begin
               mul_req.start = 1'b1;
               mul_req.x     = 64'(kk_ff);
               mul_req.y     = 32'(ll_ff);
               state_in      = BK_PWAIT;
            end
         end
         BK_PWAIT: begin
            if (mul_rsp.done) begin
               p_in     = mul_rsp.product;
               state_in = BK_SQ;
            end
         end
         BK_SQ: begin
            mul_req.start = 1'b1;
            mul_req.x     = 64'(bmag);
            mul_req.y     = bmag;
            state_in      = BK_SQWAIT;
         end
         BK_SQWAIT: begin
            if (mul_rsp.done) begin
               b2_in    = mul_rsp.product;
               t_in     = '0;
               sbit_in  = 3'd5;
               state_in = BK_SRCH;
            end
         end
         BK_SRCH: begin
            if ((cand <= 6'(LEVEL_MAX)) && (a_s <= 0) && !b_neg) begin
               t_in = cand;
            end else if ((cand <= 6'(LEVEL_MAX)) && !((a_s > 0) && b_neg)) begin
               mul_req.start = 1'b1;
               mul_req.x     = p_ff;
               mul_req.y     = 32'(unsigned'(a_sq));
               state_in      = BK_SWAIT;
            end
            if (state_in == BK_SRCH) begin
               if (sbit_ff == '0) begin
                  state_in = BK_OUT;
               end else begin
                  sbit_in = sbit_ff - 1'b1;
               end
            end
         end
         BK_SWAIT: begin
            if (mul_rsp.done) begin
               if (fits) begin
                  t_in = cand;
               end
               if (sbit_ff == '0) begin
                  state_in = BK_OUT;
               end else begin
                  sbit_in  = sbit_ff - 1'b1;
                  state_in = BK_SRCH;
               end
            end
         end
         BK_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.light_level  = t_ff;
               rsp_in.updated      = cmd_ff.interior;
               state_in            = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase

      clearing  = (state_ff == BK_CLEAR);
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      comp_ff <= comp_in;
      up_ff   <= up_in;
      lo_ff   <= lo_in;
      rd_ff   <= rd_in;
      k_ff    <= k_in;
      j_ff    <= j_in;
      d_ff    <= d_in;
      kk_ff   <= kk_in;
      ll_ff   <= ll_in;
      p_ff    <= p_in;
      b2_ff   <= b2_in;
      t_ff    <= t_in;
      sbit_ff <= sbit_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr] <= wr_up;
         lower_mem[wr_addr] <= wr_lo;
      end
      up_rd_ff <= upper_mem[rd_addr];
      lo_rd_ff <= lower_mem[rd_addr];
   end

   assert property (@(posedge clock) disable iff (reset) (state_ff == BK_CLEAR) |-> !pop)
      else $error("command taken during the table clearing pass");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> (rsp_ff.light_level <= 6'(LEVEL_MAX)))
      else $error("light level above its range");
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && !rsp_ff.updated) |-> (rsp_ff.light_level == '0))
      else $error("skipped cell carries a non-zero level");

endmodule

[hw/rtl/heightfield_normal_lighting_top.sv]
// Top level of the terrain cell lighting block: light direction registers,
// front, command queue and back end. Uses hnl_pkg, hnl_front, hnl_queue, hnl_back.
//
//  Port group  Direction  Transfer rule
//  req_*       in         cell and corner heights, taken when req_valid and !req_stall
//  rsp_*       out        light level and updated flag, taken when rsp_valid and !rsp_stall
//  csr_*       in         light direction write, taken on every csr_write_en
//
// After reset the block clears all 16384 entries of both normal tables and
// holds req_stall high meanwhile; register writes are taken throughout.
// An edge cell goes from the queue straight to the output state with level zero.
// An interior cell goes through six normal components on the shared divide
// and square-root unit, then five table reads, a three-step dot product
// and up to eight serial multiplies.
// The queue holds four items, so until it is full the front keeps taking
// transfers while the back works or while a result waits on rsp_stall.
module heightfield_normal_lighting_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hnl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hnl_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [8:0]       csr_wdata
);
   import hnl_pkg::*;

   light_type light_ff, light_in;
   cmd_type   push_cmd;
   cmd_type   head;
   logic      push;
   logic      pop;
   logic      full;
   logic      empty;
   logic      clearing;

   // A write to an index with no register behind it is simply dropped.
   always_comb begin
      light_in = light_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_LIGHT_X: light_in.x = signed'(csr_wdata);
            CSR_LIGHT_Y: light_in.y = signed'(csr_wdata);
            CSR_LIGHT_Z: light_in.z = signed'(csr_wdata);
            default:     light_in = light_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff.x <= 9'(LIGHT_RESET_X);
         light_ff.y <= 9'(LIGHT_RESET_Y);
         light_ff.z <= 9'(LIGHT_RESET_Z);
      end else begin
         light_ff <= light_in;
      end
   end

   // The front classifies each transfer and forms the triangle height steps.
   hnl_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .clearing   (clearing),
      .queue_full (full),
      .push       (push),
      .cmd        (push_cmd)
   );

   hnl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   // The back owns both normal tables and the registered result.
   hnl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .light     (light_ff),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
